// ===== design/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	localparam logic [2:0] REG_HUE_LOW  = 3'd0;
	localparam logic [2:0] REG_HUE_HIGH = 3'd1;
	localparam logic [2:0] REG_SAT_LOW  = 3'd2;
	localparam logic [2:0] REG_SAT_HIGH = 3'd3;
	localparam logic [2:0] REG_VAL_LOW  = 3'd4;
	localparam logic [2:0] REG_VAL_HIGH = 3'd5;

	localparam int NORM_SHIFT = 12;

	localparam logic [14:0] HUE_FULL  = 15'd23040;
	localparam logic [14:0] HUE_SIXTH = 15'd3840;
	localparam logic [14:0] HUE_GREEN = 15'd7680;
	localparam logic [14:0] HUE_BLUE  = 15'd15360;
	localparam logic [12:0] SV_FULL   = 13'd4096;

	typedef struct packed {
		logic [1:0] sel;
		logic       neg;
		logic       grey;
		logic       blk;
	} ctl_t;

endpackage

`default_nettype wire

// ===== design/rgbhsv_pix_if.sv =====
`default_nettype none

interface rgbhsv_pix_if;
	logic       valid;
	logic       ready;
	logic [4:0] red;
	logic [5:0] green;
	logic [4:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== design/rgbhsv_hsv_if.sv =====
`default_nettype none

interface rgbhsv_hsv_if;
	logic        valid;
	logic        ready;
	logic [14:0] hue;
	logic [12:0] saturation;
	logic [12:0] brightness;
	logic        in_window;

	modport source (output valid, output hue, output saturation, output brightness,
		output in_window, input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		input in_window, output ready);
endinterface

`default_nettype wire

// ===== design/rgbhsv_front.sv =====
`default_nettype none

module rgbhsv_front #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic [4:0]               red,
	input  wire logic [5:0]               green,
	input  wire logic [4:0]               blue,
	output logic                          valid,
	output rgbhsv_pkg::ctl_t              ctl,
	output logic [FRAC_BITS:0]            mx,
	output logic [FRAC_BITS:0]            dif,
	output logic [2*FRAC_BITS:0]          sat_num,
	output logic [FRAC_BITS+12:0]         hue_num
);

	localparam int VW = FRAC_BITS + 1;
	localparam int K  = FRAC_BITS + rgbhsv_pkg::NORM_SHIFT;
	localparam int MW = K - 4;
	localparam logic [MW-1:0] MUL5 = MW'(((64'd1 << K) + 64'd30) / 64'd31);
	localparam logic [MW-1:0] MUL6 = MW'(((64'd1 << K) + 64'd62) / 64'd63);

	logic [MW+4:0] prod_r, prod_b;
	logic [MW+5:0] prod_g;

	logic          v_s1, v_s2, v_s3;
	logic [VW-1:0] r_s1, g_s1, b_s1;

	logic [VW-1:0] mx_c, mn_c, a_c, b_c, mag_c;
	logic [1:0]    sel_c;

	logic [VW-1:0]    mx_s2, dif_s2, mag_s2;
	rgbhsv_pkg::ctl_t ctl_s2;

	logic [VW-1:0]    mx_s3, dif_s3;
	logic [2*FRAC_BITS:0] sat_num_s3;
	logic [VW+11:0]   hue_num_s3;
	rgbhsv_pkg::ctl_t ctl_s3;

	assign prod_r = (MW+5)'(red) * (MW+5)'(MUL5);
	assign prod_g = (MW+6)'(green) * (MW+6)'(MUL6);
	assign prod_b = (MW+5)'(blue) * (MW+5)'(MUL5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= prod_r[rgbhsv_pkg::NORM_SHIFT +: VW];
			g_s1 <= prod_g[rgbhsv_pkg::NORM_SHIFT +: VW];
			b_s1 <= prod_b[rgbhsv_pkg::NORM_SHIFT +: VW];
		end
	end

	always_comb begin
		mx_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		mn_c = r_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;
		if (r_s1 == mx_c) begin
			sel_c = rgbhsv_pkg::SEL_RED;
			a_c   = g_s1;
			b_c   = b_s1;
		end else if (g_s1 == mx_c) begin
			sel_c = rgbhsv_pkg::SEL_GREEN;
			a_c   = b_s1;
			b_c   = r_s1;
		end else begin
			sel_c = rgbhsv_pkg::SEL_BLUE;
			a_c   = r_s1;
			b_c   = g_s1;
		end
		mag_c = (a_c < b_c) ? (b_c - a_c) : (a_c - b_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2       <= mx_c;
			dif_s2      <= mx_c - mn_c;
			mag_s2      <= mag_c;
			ctl_s2.sel  <= sel_c;
			ctl_s2.neg  <= a_c < b_c;
			ctl_s2.grey <= mx_c == mn_c;
			ctl_s2.blk  <= mx_c == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s3      <= mx_s2;
			dif_s3     <= dif_s2;
			sat_num_s3 <= {dif_s2, {FRAC_BITS{1'b0}}};
			hue_num_s3 <= (VW+12)'(mag_s2) * (VW+12)'(rgbhsv_pkg::HUE_SIXTH);
			ctl_s3     <= ctl_s2;
		end
	end

	assign valid   = v_s3;
	assign ctl     = ctl_s3;
	assign mx      = mx_s3;
	assign dif     = dif_s3;
	assign sat_num = sat_num_s3;
	assign hue_num = hue_num_s3;

endmodule

`default_nettype wire

// ===== design/rgbhsv_div.sv =====
`default_nettype none

module rgbhsv_div #(
	parameter int NW = 25,
	parameter int DW = 13,
	parameter int QW = 13
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic [QW-1:0]      quo,
	output logic               rem_nz
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] q_s   [QW];
	logic [DW-1:0] den_s [QW-1];
	logic [QW-1:0] low_s [QW-1];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [DW-1:0] rem_i, den_i;
		logic [QW-1:0] low_i, q_i;
		logic [DW:0]   trial;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_i = DW'(num >> QW);
			assign den_i = den;
			assign low_i = num[QW-1:0];
			assign q_i   = '0;
		end else begin : g_next
			assign rem_i = rem_s[i-1];
			assign den_i = den_s[i-1];
			assign low_i = low_s[i-1];
			assign q_i   = q_s[i-1];
		end

		assign trial = {rem_i, low_i[QW-1]};
		assign take  = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
				q_s[i]   <= {q_i[QW-2:0], take};
			end
		end

		if (i < QW - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[i] <= den_i;
					low_s[i] <= {low_i[QW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo    = q_s[QW-1];
	assign rem_nz = |rem_s[QW-1];

endmodule

`default_nettype wire

// ===== design/rgb565_hsv_window_classifier_unit.sv =====
// Channel  Dir  Payload                                   Handshake
// pix      in   red[4:0] green[5:0] blue[4:0]             valid / ready
// hsv      out  hue[14:0] saturation[12:0] brightness[12:0] in_window   valid / ready
// cfg      in   cfg_index[2:0] cfg_data[14:0]             cfg_wen, no stall
//
// One pixel per clock sustained while the output is not stalled. The pipeline stages are:
// three front stages, one stage per quotient bit in the two long dividers, one output stage.
// The whole pipeline advances when the output register is empty or taken; pix.ready follows it.
// arst_n clears the valid bits and loads the window bounds to their full range.
`default_nettype none

module rgb565_hsv_window_classifier_unit #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rgbhsv_pix_if.sink       pix,
	rgbhsv_hsv_if.source     hsv,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);

	localparam int VW   = FRAC_BITS + 1;
	localparam int QW   = (FRAC_BITS + 1 > 12) ? FRAC_BITS + 1 : 12;
	localparam int SNW  = 2 * FRAC_BITS + 1;
	localparam int HNW  = VW + 12;
	localparam int CMPW = (VW > 13) ? VW : 13;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

	logic en;

	logic [14:0] hue_low_q, hue_high_q;
	logic [12:0] sat_low_q, sat_high_q, val_low_q, val_high_q;

	logic             f_valid;
	rgbhsv_pkg::ctl_t f_ctl;
	logic [VW-1:0]    f_mx, f_dif;
	logic [SNW-1:0]   f_sat_num;
	logic [HNW-1:0]   f_hue_num;

	logic [QW-1:0] sat_quo, hue_quo;
	logic          hue_rnz;

	logic             v_d   [QW];
	rgbhsv_pkg::ctl_t ctl_d [QW];
	logic [VW-1:0]    mx_d  [QW];

	rgbhsv_pkg::ctl_t ctl_e;
	logic [14:0]      base_c, h_c;
	logic [12:0]      adj_c;
	logic [VW-1:0]    s_c, mx_e;
	logic             win_c;

	logic        out_v_q, win_q;
	logic [14:0] hue_q;
	logic [12:0] sat_q, bri_q;

	assign en        = !out_v_q || hsv.ready;
	assign pix.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q  <= '0;
			hue_high_q <= rgbhsv_pkg::HUE_FULL;
			sat_low_q  <= '0;
			sat_high_q <= rgbhsv_pkg::SV_FULL;
			val_low_q  <= '0;
			val_high_q <= rgbhsv_pkg::SV_FULL;
		end else if (cfg_wen) begin
			case (cfg_index)
				rgbhsv_pkg::REG_HUE_LOW:  hue_low_q  <= cfg_data;
				rgbhsv_pkg::REG_HUE_HIGH: hue_high_q <= cfg_data;
				rgbhsv_pkg::REG_SAT_LOW:  sat_low_q  <= cfg_data[12:0];
				rgbhsv_pkg::REG_SAT_HIGH: sat_high_q <= cfg_data[12:0];
				rgbhsv_pkg::REG_VAL_LOW:  val_low_q  <= cfg_data[12:0];
				rgbhsv_pkg::REG_VAL_HIGH: val_high_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	rgbhsv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pix.valid),
		.red      (pix.red),
		.green    (pix.green),
		.blue     (pix.blue),
		.valid    (f_valid),
		.ctl      (f_ctl),
		.mx       (f_mx),
		.dif      (f_dif),
		.sat_num  (f_sat_num),
		.hue_num  (f_hue_num)
	);

	rgbhsv_div #(.NW(SNW), .DW(VW), .QW(QW)) u_sat_div (
		.clk    (clk),
		.en     (en),
		.num    (f_sat_num),
		.den    (f_mx),
		.quo    (sat_quo),
		.rem_nz ()
	);

	rgbhsv_div #(.NW(HNW), .DW(VW), .QW(QW)) u_hue_div (
		.clk    (clk),
		.en     (en),
		.num    (f_hue_num),
		.den    (f_dif),
		.quo    (hue_quo),
		.rem_nz (hue_rnz)
	);

	for (genvar i = 0; i < QW; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[i] <= 1'b0;
			end else if (en) begin
				v_d[i] <= (i == 0) ? f_valid : v_d[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_d[i] <= (i == 0) ? f_ctl : ctl_d[(i == 0) ? 0 : i-1];
				mx_d[i]  <= (i == 0) ? f_mx : mx_d[(i == 0) ? 0 : i-1];
			end
		end
	end

	assign ctl_e = ctl_d[QW-1];
	assign mx_e  = mx_d[QW-1];

	// negative red hue wraps, so its base is a full turn
	always_comb begin
		case (ctl_e.sel)
			rgbhsv_pkg::SEL_RED:   base_c = ctl_e.neg ? rgbhsv_pkg::HUE_FULL : '0;
			rgbhsv_pkg::SEL_GREEN: base_c = rgbhsv_pkg::HUE_GREEN;
			rgbhsv_pkg::SEL_BLUE:  base_c = rgbhsv_pkg::HUE_BLUE;
			default:               base_c = '0;
		endcase
		adj_c = {1'b0, hue_quo[11:0]} + 13'(hue_rnz);
		if (ctl_e.grey) begin
			h_c = '0;
		end else if (ctl_e.neg) begin
			h_c = base_c - 15'(adj_c);
		end else begin
			h_c = base_c + 15'(hue_quo[11:0]);
		end
		s_c   = ctl_e.blk ? '0 : VW'(sat_quo);
		win_c = h_c >= hue_low_q && h_c <= hue_high_q &&
			CMPW'(s_c) >= CMPW'(sat_low_q) && CMPW'(s_c) <= CMPW'(sat_high_q) &&
			CMPW'(mx_e) >= CMPW'(val_low_q) && CMPW'(mx_e) <= CMPW'(val_high_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_d[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= h_c;
			sat_q <= 13'(s_c);
			bri_q <= 13'(mx_e);
			win_q <= win_c;
		end
	end

	assign hsv.valid      = out_v_q;
	assign hsv.hue        = hue_q;
	assign hsv.saturation = sat_q;
	assign hsv.brightness = bri_q;
	assign hsv.in_window  = win_q;

	a_hue_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_d[QW-1] && !ctl_e.grey |-> hue_quo <= QW'(rgbhsv_pkg::HUE_SIXTH))
		else $error("hue quotient above one sixth of a turn");

	a_sat_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_d[QW-1] && !ctl_e.blk |-> sat_quo <= ONE_Q)
		else $error("saturation quotient above one");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> hue_q < rgbhsv_pkg::HUE_FULL)
		else $error("hue result outside one turn");

endmodule

`default_nettype wire
